@@ hdl/tec_pkg.sv @@
// text encoding classifier package: byte classes, result codes and the
// ebcdic to ascii translation table. no dependencies.
`default_nettype none

package tec_pkg;

	typedef enum logic [1:0] {
		CLS_NEVER = 2'd0,
		CLS_TEXT  = 2'd1,
		CLS_ISO   = 2'd2,
		CLS_EXT   = 2'd3
	} cls_t;

	typedef enum logic [3:0] {
		ENC_UNKNOWN  = 4'd0,
		ENC_ASCII    = 4'd1,
		ENC_UTF8_BOM = 4'd2,
		ENC_UTF8     = 4'd3,
		ENC_UTF16LE  = 4'd4,
		ENC_UTF16BE  = 4'd5,
		ENC_ISO8859  = 4'd6,
		ENC_EXTENDED = 4'd7,
		ENC_EBCDIC   = 4'd8,
		ENC_EBCDIC_I = 4'd9
	} enc_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} tec_word_t;

	localparam logic [7:0] BOM_UTF8_0 = 8'hef;
	localparam logic [7:0] BOM_UTF8_1 = 8'hbb;
	localparam logic [7:0] BOM_UTF8_2 = 8'hbf;
	localparam logic [7:0] BOM_FE     = 8'hfe;
	localparam logic [7:0] BOM_FF     = 8'hff;

	localparam logic [7:0] EBC2ASC [256] = '{
		8'd0,   8'd1,   8'd2,   8'd3,   8'd156, 8'd9,   8'd134, 8'd127,
		8'd151, 8'd141, 8'd142, 8'd11,  8'd12,  8'd13,  8'd14,  8'd15,
		8'd16,  8'd17,  8'd18,  8'd19,  8'd157, 8'd133, 8'd8,   8'd135,
		8'd24,  8'd25,  8'd146, 8'd143, 8'd28,  8'd29,  8'd30,  8'd31,
		8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd10,  8'd23,  8'd27,
		8'd136, 8'd137, 8'd138, 8'd139, 8'd140, 8'd5,   8'd6,   8'd7,
		8'd144, 8'd145, 8'd22,  8'd147, 8'd148, 8'd149, 8'd150, 8'd4,
		8'd152, 8'd153, 8'd154, 8'd155, 8'd20,  8'd21,  8'd158, 8'd26,
		8'd32,  8'd160, 8'd161, 8'd162, 8'd163, 8'd164, 8'd165, 8'd166,
		8'd167, 8'd168, 8'd213, 8'd46,  8'd60,  8'd40,  8'd43,  8'd124,
		8'd38,  8'd169, 8'd170, 8'd171, 8'd172, 8'd173, 8'd174, 8'd175,
		8'd176, 8'd177, 8'd33,  8'd36,  8'd42,  8'd41,  8'd59,  8'd126,
		8'd45,  8'd47,  8'd178, 8'd179, 8'd180, 8'd181, 8'd182, 8'd183,
		8'd184, 8'd185, 8'd203, 8'd44,  8'd37,  8'd95,  8'd62,  8'd63,
		8'd186, 8'd187, 8'd188, 8'd189, 8'd190, 8'd191, 8'd192, 8'd193,
		8'd194, 8'd96,  8'd58,  8'd35,  8'd64,  8'd39,  8'd61,  8'd34,
		8'd195, 8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103,
		8'd104, 8'd105, 8'd196, 8'd197, 8'd198, 8'd199, 8'd200, 8'd201,
		8'd202, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112,
		8'd113, 8'd114, 8'd94,  8'd204, 8'd205, 8'd206, 8'd207, 8'd208,
		8'd209, 8'd229, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120,
		8'd121, 8'd122, 8'd210, 8'd211, 8'd212, 8'd91,  8'd214, 8'd215,
		8'd216, 8'd217, 8'd218, 8'd219, 8'd220, 8'd221, 8'd222, 8'd223,
		8'd224, 8'd225, 8'd226, 8'd227, 8'd228, 8'd93,  8'd230, 8'd231,
		8'd123, 8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,
		8'd72,  8'd73,  8'd232, 8'd233, 8'd234, 8'd235, 8'd236, 8'd237,
		8'd125, 8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,  8'd80,
		8'd81,  8'd82,  8'd238, 8'd239, 8'd240, 8'd241, 8'd242, 8'd243,
		8'd92,  8'd159, 8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,
		8'd89,  8'd90,  8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd249,
		8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,
		8'd56,  8'd57,  8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255
	};

	function automatic cls_t byte_class(input logic [7:0] b);
		cls_t c;
		if (b >= 8'ha0) begin
			c = CLS_ISO;
		end else if (b == 8'h85) begin
			c = CLS_TEXT;
		end else if (b >= 8'h80) begin
			c = CLS_EXT;
		end else if (b >= 8'h20) begin
			c = (b == 8'h7f) ? CLS_NEVER : CLS_TEXT;
		end else if ((b >= 8'h07 && b <= 8'h0a) || b == 8'h0c || b == 8'h0d || b == 8'h1b) begin
			c = CLS_TEXT;
		end else begin
			c = CLS_NEVER;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ hdl/tec_tracker.sv @@
// per-buffer flag tracking, utf-8 checker and final class selection.
// depends on tec_pkg.
`default_nettype none

module tec_tracker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire tec_pkg::tec_word_t word_in,
	output tec_pkg::enc_t          enc_class
);
	import tec_pkg::*;

	logic       ascii_ok_q, latin_ok_q, extended_ok_q, ebc_ascii_ok_q, ebc_latin_ok_q;
	logic       utf_invalid_q, utf_control_q, utf_multi_q;
	logic [2:0] cont_left_q;
	logic [2:0] bytes_seen_q;
	logic [7:0] lead_q [3];

	logic       ascii_ok_n, latin_ok_n, extended_ok_n, ebc_ascii_ok_n, ebc_latin_ok_n;
	logic       utf_invalid_n, utf_control_n, utf_multi_n;
	logic [2:0] cont_left_n;
	logic [2:0] bytes_seen_n;
	logic [7:0] lead_n [3];
	logic [7:0] b;
	cls_t       c, e;
	logic       utf_clean;

	assign b = word_in.data_byte;
	assign c = byte_class(b);
	assign e = byte_class(EBC2ASC[b]);

	always_comb begin
		ascii_ok_n     = ascii_ok_q && c == CLS_TEXT;
		latin_ok_n     = latin_ok_q && (c == CLS_TEXT || c == CLS_ISO);
		extended_ok_n  = extended_ok_q && c != CLS_NEVER;
		ebc_ascii_ok_n = ebc_ascii_ok_q && e == CLS_TEXT;
		ebc_latin_ok_n = ebc_latin_ok_q && (e == CLS_TEXT || e == CLS_ISO);

		utf_invalid_n = utf_invalid_q;
		utf_control_n = utf_control_q;
		utf_multi_n   = utf_multi_q;
		cont_left_n   = cont_left_q;
		if (!utf_invalid_q) begin
			if (cont_left_q != 3'd0) begin
				if (b[7:6] != 2'b10) begin
					utf_invalid_n = 1'b1;
				end else begin
					cont_left_n = cont_left_q - 3'd1;
					if (cont_left_q == 3'd1) utf_multi_n = 1'b1;
				end
			end else if (!b[7]) begin
				if (c != CLS_TEXT) utf_control_n = 1'b1;
			end else if (!b[6]) begin
				utf_invalid_n = 1'b1;
			end else if (!b[5]) begin
				cont_left_n = 3'd1;
			end else if (!b[4]) begin
				cont_left_n = 3'd2;
			end else if (!b[3]) begin
				cont_left_n = 3'd3;
			end else if (!b[2]) begin
				cont_left_n = 3'd4;
			end else if (!b[1]) begin
				cont_left_n = 3'd5;
			end else begin
				utf_invalid_n = 1'b1;
			end
		end

		lead_n = lead_q;
		if (bytes_seen_q < 3'd3) lead_n[bytes_seen_q[1:0]] = b;
		bytes_seen_n = (bytes_seen_q < 3'd4) ? bytes_seen_q + 3'd1 : bytes_seen_q;
	end

	// class priority on the state after this word
	always_comb begin
		utf_clean = !utf_invalid_n && !utf_control_n;
		if (ascii_ok_n) begin
			enc_class = ENC_ASCII;
		end else if (bytes_seen_n >= 3'd4 && lead_n[0] == BOM_UTF8_0 &&
		             lead_n[1] == BOM_UTF8_1 && lead_n[2] == BOM_UTF8_2 && utf_clean) begin
			enc_class = ENC_UTF8_BOM;
		end else if (utf_clean && utf_multi_n) begin
			enc_class = ENC_UTF8;
		end else if (bytes_seen_n >= 3'd2 && lead_n[0] == BOM_FF && lead_n[1] == BOM_FE) begin
			enc_class = ENC_UTF16LE;
		end else if (bytes_seen_n >= 3'd2 && lead_n[0] == BOM_FE && lead_n[1] == BOM_FF) begin
			enc_class = ENC_UTF16BE;
		end else if (latin_ok_n) begin
			enc_class = ENC_ISO8859;
		end else if (extended_ok_n) begin
			enc_class = ENC_EXTENDED;
		end else if (ebc_ascii_ok_n) begin
			enc_class = ENC_EBCDIC;
		end else if (ebc_latin_ok_n) begin
			enc_class = ENC_EBCDIC_I;
		end else begin
			enc_class = ENC_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_ok_q     <= 1'b1;
			latin_ok_q     <= 1'b1;
			extended_ok_q  <= 1'b1;
			ebc_ascii_ok_q <= 1'b1;
			ebc_latin_ok_q <= 1'b1;
			utf_invalid_q  <= 1'b0;
			utf_control_q  <= 1'b0;
			utf_multi_q    <= 1'b0;
			cont_left_q    <= 3'd0;
			bytes_seen_q   <= 3'd0;
			lead_q         <= '{8'd0, 8'd0, 8'd0};
		end else if (step) begin
			if (word_in.last_byte) begin
				ascii_ok_q     <= 1'b1;
				latin_ok_q     <= 1'b1;
				extended_ok_q  <= 1'b1;
				ebc_ascii_ok_q <= 1'b1;
				ebc_latin_ok_q <= 1'b1;
				utf_invalid_q  <= 1'b0;
				utf_control_q  <= 1'b0;
				utf_multi_q    <= 1'b0;
				cont_left_q    <= 3'd0;
				bytes_seen_q   <= 3'd0;
				lead_q         <= '{8'd0, 8'd0, 8'd0};
			end else begin
				ascii_ok_q     <= ascii_ok_n;
				latin_ok_q     <= latin_ok_n;
				extended_ok_q  <= extended_ok_n;
				ebc_ascii_ok_q <= ebc_ascii_ok_n;
				ebc_latin_ok_q <= ebc_latin_ok_n;
				utf_invalid_q  <= utf_invalid_n;
				utf_control_q  <= utf_control_n;
				utf_multi_q    <= utf_multi_n;
				cont_left_q    <= cont_left_n;
				bytes_seen_q   <= bytes_seen_n;
				lead_q         <= lead_n;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/text_encoding_classifier.sv @@
// text encoding classifier top level: input register, tracker, result register.
// depends on tec_pkg and tec_tracker.
//
//   channel  | dir | tdata              | side band
//   s_axis   | in  | [7:0] data_byte    | tlast = last_byte
//   m_axis   | out | [3:0] encoding_class, [7:4] zero | none
//
// one word per cycle sustained, save that a last word waits while a result stalls;
// each word sits in the input register; only the last word's class is loaded into the result register.
// arst_n clears the valid flags and all per-buffer tracking flags.
// a stalled result holds only a last word in the input register; other words
// keep flowing while the result waits.
`default_nettype none

module text_encoding_classifier (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic       s_axis_tlast,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata    // [3:0] encoding_class, [7:4] zero
);
	import tec_pkg::*;

	logic      valid_s1;
	tec_word_t word_s1;
	logic      out_free;
	logic      adv_s1;
	enc_t      enc_class;
	enc_t      class_q;

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign adv_s1        = valid_s1 && (!word_s1.last_byte || out_free);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			word_s1.data_byte <= s_axis_tdata;
			word_s1.last_byte <= s_axis_tlast;
		end
	end

	tec_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.word_in   (word_s1),
		.enc_class (enc_class)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= adv_s1 && word_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && word_s1.last_byte) begin
			class_q <= enc_class;
		end
	end

	assign m_axis_tdata = {4'd0, class_q};

endmodule

`default_nettype wire
